/* src/rrss_pkg.sv */
package rrss_pkg;

  localparam int MAX_THREADS = 8;
  localparam int NUM_AREAS   = 16;

  localparam int IDX_W   = $clog2(MAX_THREADS);
  localparam int CNT_W   = $clog2(MAX_THREADS + 1);
  localparam int TAG_W   = 8;
  localparam int AREA_W  = 4;
  localparam int TIME_W  = 32;
  localparam int TICK_W  = 16;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 4;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DISPATCH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_OK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HALT      = 2'd3;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [AREA_W-1:0] area;
    logic [TIME_W-1:0] left_at;
    logic [TIME_W-1:0] sleep;
  } cell_data_t;

  typedef struct packed {
    logic load;   // new thread enters this cell
    logic shift;  // take the neighbour's entry (retire compaction)
    logic park;   // record leave time and sleep
  } cell_ctl_t;

endpackage

/* src/rrss_in_if.sv */
interface rrss_in_if;
  import rrss_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic                completed;
  logic [TIME_W-1:0]   sleep_ms;
  logic [TAG_W-1:0]    thread_tag;
  logic [AREA_W-1:0]   area_index;

  modport source (
    output valid, command, completed, sleep_ms, thread_tag, area_index,
    input  ready
  );

  modport sink (
    input  valid, command, completed, sleep_ms, thread_tag, area_index,
    output ready
  );

endinterface

/* src/rrss_out_if.sv */
interface rrss_out_if;
  import rrss_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TAG_W-1:0]    next_tag;
  logic [SLOT_W-1:0]   next_slot;
  logic [MASK_W-1:0]   area_mask;
  logic [COUNT_W-1:0]  thread_count;

  modport source (
    output valid, kind, next_tag, next_slot, area_mask, thread_count,
    input  ready
  );

  modport sink (
    input  valid, kind, next_tag, next_slot, area_mask, thread_count,
    output ready
  );

endinterface

/* src/round_robin_sleep_scheduler.sv */
// Round-robin thread scheduler with sleep. Threads sit in a row of cells, one
// per table slot, each checking its own due time against the millisecond
// clock every cycle; retiring a thread shifts all later cells down by one at
// once. A tick with no dispatch pending finishes in idle; an add or a refused
// add goes through the emit state. A switch (or a tick that retries a pending
// dispatch) goes through settle, then scans the slots, one per cycle from the
// current index, to the first ready one and emits it; if none is ready it idles
// with the dispatch pending, and a switch that finds the table empty halts.
// Results go through an output register, so a new command may be taken while
// the previous result still waits; the next result then waits for that
// transfer. tick_interval is written through cfg_we.
module round_robin_sleep_scheduler
  import rrss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  rrss_in_if.sink            in_ch,
  rrss_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [TICK_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [TICK_W-1:0]   interval_r;
  logic [TIME_W-1:0]   clock_r, clock_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                running_r, running_nxt;
  logic                pending_r, pending_nxt;
  logic [NUM_AREAS-1:0] areas_r, areas_nxt;
  logic                is_switch_r, is_switch_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]    scan_n_r, scan_n_nxt;
  logic [KIND_W-1:0]   res_kind_r, res_kind_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  cell_ctl_t           ctl      [MAX_THREADS];
  cell_data_t          cell_q   [MAX_THREADS];
  logic [MAX_THREADS-1:0] cell_ready;

  logic                accept;
  logic                idx_valid;
  logic                do_retire, do_park, do_load;
  logic [AREA_W-1:0]   cur_area;
  logic [IDX_W-1:0]    scan_wrap;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_valid   = ({1'b0, idx_r} < count_r) && (count_r != '0);
  assign cur_area    = cell_q[idx_r].area;

  assign do_retire = accept && (in_ch.command == CMD_SWITCH) && running_r &&
                     idx_valid && in_ch.completed;
  assign do_park   = accept && (in_ch.command == CMD_SWITCH) && running_r &&
                     idx_valid && !in_ch.completed;
  assign do_load   = accept && (in_ch.command == CMD_ADD) &&
                     (count_r < CNT_W'(MAX_THREADS));

  assign scan_wrap = (CNT_W'(scan_idx_r) + CNT_W'(1) == count_r) ?
                     '0 : scan_idx_r + IDX_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      ctl[i].load  = do_load && (CNT_W'(i) == count_r);
      ctl[i].shift = do_retire && (IDX_W'(i) >= idx_r) &&
                     (CNT_W'(i + 1) < count_r);
      ctl[i].park  = do_park && (IDX_W'(i) == idx_r);
    end
  end

  for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
    cell_data_t nb;
    if (g < MAX_THREADS - 1) begin : g_nb
      assign nb = cell_q[g + 1];
    end else begin : g_last
      assign nb = cell_q[g];
    end
    rrss_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .clock_ms (clock_r),
      .new_tag  (in_ch.thread_tag),
      .new_area (in_ch.area_index),
      .sleep_ms (in_ch.sleep_ms),
      .nb_data  (nb),
      .data     (cell_q[g]),
      .ready    (cell_ready[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    running_nxt   = running_r;
    pending_nxt   = pending_r;
    areas_nxt     = areas_r;
    is_switch_nxt = is_switch_r;
    scan_idx_nxt  = scan_idx_r;
    scan_n_nxt    = scan_n_r;
    res_kind_nxt  = res_kind_r;
    res_tag_nxt   = res_tag_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_slot_nxt  = out_slot_r;
    out_mask_nxt  = out_mask_r;
    out_count_nxt = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_TICK: begin
              clock_nxt     = clock_r + TIME_W'(interval_r);
              is_switch_nxt = 1'b0;
              if (pending_r) begin
                state_nxt = ST_SETTLE;
              end
            end
            CMD_SWITCH: begin
              is_switch_nxt = 1'b1;
              state_nxt     = ST_SETTLE;
              if (do_retire) begin
                if (32'(cur_area) < NUM_AREAS) begin
                  areas_nxt[cur_area] = 1'b0;
                end
                if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
                  idx_nxt = '0;
                end
                count_nxt = count_r - CNT_W'(1);
              end else if (do_park) begin
                idx_nxt = (CNT_W'(idx_r) + CNT_W'(1) == count_r) ?
                          '0 : idx_r + IDX_W'(1);
              end
            end
            CMD_ADD: begin
              state_nxt = ST_EMIT;
              if (do_load) begin
                if (32'(in_ch.area_index) < NUM_AREAS) begin
                  areas_nxt[in_ch.area_index] = 1'b1;
                end
                count_nxt    = count_r + CNT_W'(1);
                res_kind_nxt = KIND_ADD_OK;
                res_tag_nxt  = in_ch.thread_tag;
                res_slot_nxt = SLOT_W'(count_r);
              end else begin
                res_kind_nxt = KIND_ADD_FULL;
                res_tag_nxt  = '0;
                res_slot_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SETTLE: begin
        // cells' ready flags are registered here from the updated clock and entries, for the scan
        if (count_r == '0) begin
          running_nxt = 1'b0;
          pending_nxt = 1'b0;
          if (is_switch_r) begin
            idx_nxt      = '0;
            res_kind_nxt = KIND_HALT;
            res_tag_nxt  = '0;
            res_slot_nxt = '0;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          scan_idx_nxt = idx_valid ? idx_r : '0;
          scan_n_nxt   = '0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cell_ready[scan_idx_r]) begin
          idx_nxt      = scan_idx_r;
          pending_nxt  = 1'b0;
          running_nxt  = 1'b1;
          res_kind_nxt = KIND_DISPATCH;
          res_tag_nxt  = cell_q[scan_idx_r].tag;
          res_slot_nxt = SLOT_W'(scan_idx_r);
          state_nxt    = ST_EMIT;
        end else if (scan_n_r == count_r - CNT_W'(1)) begin
          idx_nxt     = scan_wrap;
          pending_nxt = 1'b1;
          running_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          scan_idx_nxt = scan_wrap;
          scan_n_nxt   = scan_n_r + CNT_W'(1);
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_tag_nxt   = res_tag_r;
          out_slot_nxt  = res_slot_r;
          out_mask_nxt  = MASK_W'(areas_r);
          out_count_nxt = COUNT_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      interval_r  <= TICK_RESET;
      clock_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      running_r   <= 1'b0;
      pending_r   <= 1'b0;
      areas_r     <= '0;
      is_switch_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      clock_r     <= clock_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      running_r   <= running_nxt;
      pending_r   <= pending_nxt;
      areas_r     <= areas_nxt;
      is_switch_r <= is_switch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r  <= scan_idx_nxt;
    scan_n_r    <= scan_n_nxt;
    res_kind_r  <= res_kind_nxt;
    res_tag_r   <= res_tag_nxt;
    res_slot_r  <= res_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_slot_r  <= out_slot_nxt;
    out_mask_r  <= out_mask_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.next_tag     = out_tag_r;
  assign out_ch.next_slot    = out_slot_r;
  assign out_ch.area_mask    = out_mask_r;
  assign out_ch.thread_count = out_count_r;

endmodule

/* src/rrss_cell.sv */
module rrss_cell
  import rrss_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [TIME_W-1:0] clock_ms,
  input  logic [TAG_W-1:0]  new_tag,
  input  logic [AREA_W-1:0] new_area,
  input  logic [TIME_W-1:0] sleep_ms,
  input  cell_data_t        nb_data,
  output cell_data_t        data,
  output logic              ready
);

  cell_data_t data_r;
  logic       ready_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r.tag     <= new_tag;
      data_r.area    <= new_area;
      data_r.left_at <= '0;
      data_r.sleep   <= '0;
    end else if (ctl.shift) begin
      data_r <= nb_data;
    end else if (ctl.park) begin
      data_r.left_at <= clock_ms;
      data_r.sleep   <= sleep_ms;
    end
    // due time in one extra bit so it never wraps
    ready_r <= {1'b0, clock_ms} >= ({1'b0, data_r.left_at} + {1'b0, data_r.sleep});
  end

  assign data  = data_r;
  assign ready = ready_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rrss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int STALL_MAX      = 13;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 260;
  localparam int N_DIRECTED     = 26;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              completed;
    logic [TIME_W-1:0] sleep_ms;
    logic [TAG_W-1:0]  thread_tag;
    logic [AREA_W-1:0] area_index;
  } sched_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   next_tag;
    logic [SLOT_W-1:0]  next_slot;
    logic [MASK_W-1:0]  area_mask;
    logic [COUNT_W-1:0] thread_count;
  } sched_result_t;

  typedef struct packed {
    sched_cmd_t    cmd;
    logic          typed;   // result below is checked as written
    sched_result_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TICK_W-1:0] cfg_wdata;
  logic sink_ready = 1'b0;

  rrss_in_if  in_ch ();
  rrss_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  round_robin_sleep_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Scheduler shadow state
  logic [TAG_W-1:0]  slot_tag     [MAX_THREADS];
  logic [AREA_W-1:0] slot_area    [MAX_THREADS];
  logic [TIME_W-1:0] slot_left_at [MAX_THREADS];
  logic [TIME_W-1:0] slot_sleep   [MAX_THREADS];
  int                threads = 0;
  int                run_idx = 0;
  logic [TIME_W-1:0] now_ms = '0;
  bit                running = 1'b0;
  bit                dispatch_waiting = 1'b0;
  logic [MASK_W-1:0] areas_busy = '0;
  logic [TICK_W-1:0] tick_ms = TICK_RESET;

  sched_result_t due_results [$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_SWITCH, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b1,
      '{KIND_HALT, 8'h00, 3'd0, 16'h0000, 4'd0}},
    '{'{CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, 8'hFF, 4'hF}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'hFF, 4'd15}, 1'b1,
      '{KIND_ADD_OK, 8'hFF, 3'd0, 16'h8000, 4'd1}},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    // area already taken
    '{'{CMD_ADD, 1'b0, 32'd0, 8'hA5, 4'd0}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h5A, 4'd7}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h01, 4'd1}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h02, 4'd2}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h80, 4'd8}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h7F, 4'd15}, 1'b1,
      '{KIND_ADD_OK, 8'h7F, 3'd7, 16'h8187, 4'd8}},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h77, 4'd9}, 1'b1,
      '{KIND_ADD_FULL, 8'h00, 3'd0, 16'h8187, 4'd8}},
    '{'{CMD_SWITCH, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    // due time past the 32-bit clock range: never ready
    '{'{CMD_SWITCH, 1'b0, 32'hFFFF_FFFF, 8'h00, 4'd0}, 1'b0, '0},
    // nothing ready, dispatch left waiting
    '{'{CMD_SWITCH, 1'b0, 32'd20, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    '{'{CMD_ADD, 1'b0, 32'd0, 8'h33, 4'd5}, 1'b0, '0},
    '{'{CMD_TICK, 1'b0, 32'd0, 8'h00, 4'd0}, 1'b0, '0},
    // retire the last slot, index wraps
    '{'{CMD_SWITCH, 1'b1, 32'd0, 8'h00, 4'd0}, 1'b0, '0}
  };

  function automatic sched_result_t report(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                           int slot);
    return '{kind, tag, SLOT_W'(slot), areas_busy, COUNT_W'(threads)};
  endfunction

  // Round-robin search for the first thread whose sleep has run out
  function automatic bit find_ready(output sched_result_t r);
    int idx;
    logic [TIME_W:0] wake_at;
    r = '0;
    if (threads == 0) begin
      dispatch_waiting = 1'b0;
      running = 1'b0;
      return 1'b0;
    end
    idx = (run_idx < threads) ? run_idx : 0;
    for (int n = 0; n < threads; n++) begin
      wake_at = {1'b0, slot_left_at[idx]} + {1'b0, slot_sleep[idx]};
      if ({1'b0, now_ms} >= wake_at) begin
        run_idx = idx;
        dispatch_waiting = 1'b0;
        running = 1'b1;
        r = report(KIND_DISPATCH, slot_tag[idx], idx);
        return 1'b1;
      end
      idx = (idx + 1) % threads;
    end
    run_idx = idx;
    dispatch_waiting = 1'b1;
    running = 1'b0;
    return 1'b0;
  endfunction

  function automatic void leave_processor(bit done, logic [TIME_W-1:0] sleep);
    int idx;
    idx = run_idx;
    if (threads == 0 || idx >= threads)
      return;
    if (done) begin
      areas_busy[slot_area[idx]] = 1'b0;
      for (int i = idx; i + 1 < threads; i++) begin
        slot_tag[i]     = slot_tag[i + 1];
        slot_area[i]    = slot_area[i + 1];
        slot_left_at[i] = slot_left_at[i + 1];
        slot_sleep[i]   = slot_sleep[i + 1];
      end
      if (idx == threads - 1)
        run_idx = 0;
      threads--;
    end else begin
      slot_left_at[idx] = now_ms;
      slot_sleep[idx]   = sleep;
      run_idx = (idx + 1) % threads;
    end
  endfunction

  function automatic bit schedule_step(sched_cmd_t c, output sched_result_t r);
    r = '0;
    case (c.command)
      CMD_TICK: begin
        now_ms = now_ms + TIME_W'(tick_ms);
        if (dispatch_waiting)
          return find_ready(r);
        return 1'b0;
      end
      CMD_SWITCH: begin
        if (running)
          leave_processor(c.completed, c.sleep_ms);
        if (threads == 0) begin
          running = 1'b0;
          dispatch_waiting = 1'b0;
          run_idx = 0;
          r = report(KIND_HALT, '0, 0);
          return 1'b1;
        end
        return find_ready(r);
      end
      CMD_ADD: begin
        if (threads >= MAX_THREADS) begin
          r = report(KIND_ADD_FULL, '0, 0);
          return 1'b1;
        end
        slot_tag[threads]     = c.thread_tag;
        slot_area[threads]    = c.area_index;
        slot_left_at[threads] = '0;
        slot_sleep[threads]   = '0;
        areas_busy[c.area_index] = 1'b1;
        threads++;
        r = report(KIND_ADD_OK, c.thread_tag, threads - 1);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic sched_cmd_t random_command();
    sched_cmd_t c;
    int pick;
    c.completed  = ($urandom_range(0, 99) < 30);
    c.sleep_ms   = $urandom;
    c.thread_tag = TAG_W'($urandom);
    c.area_index = AREA_W'($urandom);
    pick = $urandom_range(0, 99);
    if (threads < 2 && pick >= 40)
      pick = 80;
    if (pick < 4)
      c.command = CMD_UNUSED;
    else if (pick < 34)
      c.command = CMD_TICK;
    else if (pick < 70)
      c.command = CMD_SWITCH;
    else
      c.command = CMD_ADD;
    // a parked thread has to wake within reach of the clock, else its slot is lost
    if (c.command == CMD_SWITCH && running && !c.completed) begin
      case ($urandom_range(0, 3))
        0:       c.sleep_ms = '0;
        1:       c.sleep_ms = $urandom_range(0, 40);
        default: c.sleep_ms = $urandom_range(0, 4 * tick_ms);
      endcase
    end
    return c;
  endfunction

  task automatic send_command(sched_cmd_t c, bit typed, sched_result_t typed_result);
    int gap;
    bit has_result;
    sched_result_t r;
    gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.command;
    in_ch.completed  <= c.completed;
    in_ch.sleep_ms   <= c.sleep_ms;
    in_ch.thread_tag <= c.thread_tag;
    in_ch.area_index <= c.area_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has_result = schedule_step(c, r);
    if (typed)
      due_results.push_back(typed_result);
    else if (has_result)
      due_results.push_back(r);
  endtask

  // Only once the block is quiet: all results in and any resultless command drained
  task automatic write_tick_interval(logic [TICK_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    tick_ms = value;
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    sched_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d tag %0h slot %0d mask %h count %0d", $time,
               out_ch.kind, out_ch.next_tag, out_ch.next_slot, out_ch.area_mask,
               out_ch.thread_count);
      errors++;
      return;
    end
    want = due_results.pop_front();
    check_field("kind", 32'(want.kind), 32'(out_ch.kind));
    check_field("next_tag", 32'(want.next_tag), 32'(out_ch.next_tag));
    check_field("next_slot", 32'(want.next_slot), 32'(out_ch.next_slot));
    check_field("area_mask", 32'(want.area_mask), 32'(out_ch.area_mask));
    check_field("thread_count", 32'(want.thread_count), 32'(out_ch.thread_count));
  endtask

  always @(posedge clk) begin : result_sink
    int stall;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ch.valid && sink_ready) begin
      check_result();
      stall = calm ? 0 : $urandom_range(0, STALL_MAX);
      stall_left <= stall;
      sink_ready <= (stall == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Cycles without a transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_TICK;
    in_ch.completed  <= 1'b0;
    in_ch.sleep_ms   <= '0;
    in_ch.thread_tag <= '0;
    in_ch.area_index <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_command(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].result);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_tick_interval(16'hFFFF);
        1:       write_tick_interval(16'd1);
        2:       write_tick_interval(TICK_W'($urandom_range(2, 65534)));
        default: write_tick_interval(TICK_W'($urandom_range(2, 60)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0)
          calm = ($urandom_range(0, 3) == 0);
        send_command(random_command(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
